// ===== design/fdmd_pkg.sv =====
// Package for the frame-difference motion detector: payload structs,
// register index codes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package fdmd_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int COORD_W     = 12;
	localparam int SIZE_W      = 13;
	localparam int COUNT_W     = 25;
	localparam int PERMILLE_W  = 10;
	localparam int PERCENT_W   = 7;
	localparam int TOL_W       = 9;
	// count * 1000 and W * H * permille both fit here
	localparam int SCALED_W    = 35;
	localparam int AREA_W      = 25;
	localparam int CFG_INDEX_W = 2;

	localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COORD_W-1:0]  COORD_MAX = {COORD_W{1'b1}};
	localparam logic [SIZE_W-1:0]   WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0]   HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);
	localparam logic [SCALED_W-1:0] PERMILLE_SCALE = SCALED_W'(1000);

	// floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
	localparam logic [12:0] PERCENT_RECIP = 13'd5243;
	localparam int          PERCENT_SHIFT = 19;

	// cycles that the derived tolerance and area products need to follow a write
	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TOLERANCE_PERCENT = 2'd0,
		CFG_CHANGE_PERMILLE   = 2'd1,
		CFG_FRAME_WIDTH       = 2'd2,
		CFG_FRAME_HEIGHT      = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] first_blue;
		logic [7:0] first_green;
		logic [7:0] first_red;
		logic [7:0] second_blue;
		logic [7:0] second_green;
		logic [7:0] second_red;
	} pixel_pair_t;

	typedef struct packed {
		logic [7:0]         out_blue;
		logic [7:0]         out_green;
		logic [7:0]         out_red;
		logic               pixel_changed;
		logic               frame_end;
		logic [3:0]         status_flags;
		logic [COUNT_W-1:0] changed_count;
		logic [COORD_W-1:0] box_min_x;
		logic [COORD_W-1:0] box_max_x;
		logic [COORD_W-1:0] box_min_y;
		logic [COORD_W-1:0] box_max_y;
	} result_t;

endpackage

// ===== design/frame_difference_motion_detect.sv =====
// Frame-difference motion detector: top level, one module.
// Depends on fdmd_pkg for payload structs, register codes and constants.
// An accepted pixel pair passes through the input register and then the result register.
// Throughput: one pixel pair per clock; the result stall and the settle stall hold it back.
// After reset or a configuration write the pixel input stalls while the tolerance and the
// frame-area product settle; configuration writes are always taken (cfg_ready is high).
// Reset (arst_n low, asynchronous) restores 10 %, 50 permille, 640 x 480 and an empty frame.
`timescale 1ns / 1ps

module frame_difference_motion_detect (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// pixel pair channel
	input  logic                                   pix_valid,
	output logic                                   pix_stall,
	input  fdmd_pkg::pixel_pair_t                  pix,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output fdmd_pkg::result_t                      res,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [fdmd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [fdmd_pkg::SIZE_W-1:0]            cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [fdmd_pkg::PERCENT_W-1:0]  tol_percent_q;
	logic [fdmd_pkg::PERMILLE_W-1:0] permille_q;
	logic [fdmd_pkg::SIZE_W-1:0]     width_q;
	logic [fdmd_pkg::SIZE_W-1:0]     height_q;
	logic [1:0]                      settle_q;
	logic                            cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_percent_q <= fdmd_pkg::PERCENT_W'(10);
			permille_q    <= fdmd_pkg::PERMILLE_W'(50);
			width_q       <= fdmd_pkg::SIZE_W'(640);
			height_q      <= fdmd_pkg::SIZE_W'(480);
		end else if (cfg_wr) begin
			unique case (fdmd_pkg::cfg_index_t'(cfg_index))
				fdmd_pkg::CFG_TOLERANCE_PERCENT: tol_percent_q <= cfg_data[fdmd_pkg::PERCENT_W-1:0];
				fdmd_pkg::CFG_CHANGE_PERMILLE:   permille_q    <= cfg_data[fdmd_pkg::PERMILLE_W-1:0];
				fdmd_pkg::CFG_FRAME_WIDTH:       width_q       <= cfg_data;
				fdmd_pkg::CFG_FRAME_HEIGHT:      height_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the pixel input after reset and after each write until the
	// derived values below have caught up with the registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= fdmd_pkg::SETTLE_CYCLES;
		end else if (cfg_wr) begin
			settle_q <= fdmd_pkg::SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// ------------------------------------------------------------------
	// Derived configuration: effective frame size, tolerance, area product
	// ------------------------------------------------------------------
	logic [fdmd_pkg::SIZE_W-1:0]   eff_width;
	logic [fdmd_pkg::SIZE_W-1:0]   eff_height;
	logic [14:0]                   tol_scaled;
	logic [27:0]                   tol_prod;
	logic [fdmd_pkg::TOL_W-1:0]    tol_q;
	logic [2*fdmd_pkg::SIZE_W-1:0] area_full;
	logic [fdmd_pkg::AREA_W-1:0]   area_q;
	logic [fdmd_pkg::SCALED_W-1:0] thr_prod_q;

	// A zero size counts as one, an oversize one as the limit.
	always_comb begin
		if (width_q == '0) begin
			eff_width = fdmd_pkg::SIZE_W'(1);
		end else if (width_q > fdmd_pkg::WIDTH_LIMIT) begin
			eff_width = fdmd_pkg::WIDTH_LIMIT;
		end else begin
			eff_width = width_q;
		end
		if (height_q == '0) begin
			eff_height = fdmd_pkg::SIZE_W'(1);
		end else if (height_q > fdmd_pkg::HEIGHT_LIMIT) begin
			eff_height = fdmd_pkg::HEIGHT_LIMIT;
		end else begin
			eff_height = height_q;
		end
	end

	// tolerance = floor(255 * percent / 100) by reciprocal multiply
	assign tol_scaled = 15'(tol_percent_q) * 15'd255;
	assign tol_prod   = 28'(tol_scaled) * 28'(fdmd_pkg::PERCENT_RECIP);
	assign area_full  = eff_width * eff_height;

	// The threshold test count > floor(A * p / 1000) is the same as
	// count * 1000 > A * p, so only the product is kept here.
	always_ff @(posedge clk) begin
		tol_q      <= tol_prod[fdmd_pkg::PERCENT_SHIFT +: fdmd_pkg::TOL_W];
		area_q     <= area_full[fdmd_pkg::AREA_W-1:0];
		thr_prod_q <= fdmd_pkg::SCALED_W'(area_q) * fdmd_pkg::SCALED_W'(permille_q);
	end

	// ------------------------------------------------------------------
	// Handshake: input register (s1) and result register (s2)
	// ------------------------------------------------------------------
	logic v_s1;
	logic v_s2;
	logic adv_s2;
	logic move_s1;
	logic accept;

	assign adv_s2    = ~v_s2 | ~res_stall;
	assign move_s1   = v_s1 & adv_s2;
	assign pix_stall = (settle_q != 2'd0) | (v_s1 & ~adv_s2);
	assign accept    = pix_valid & ~pix_stall;
	assign res_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (move_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Raster position, advanced as each request is taken
	// ------------------------------------------------------------------
	logic [fdmd_pkg::COORD_W-1:0] col_q;
	logic [fdmd_pkg::COORD_W-1:0] row_q;
	logic                         last_col;
	logic                         last_row;

	assign last_col = ({1'b0, col_q} + fdmd_pkg::SIZE_W'(1)) >= eff_width;
	assign last_row = ({1'b0, row_q} + fdmd_pkg::SIZE_W'(1)) >= eff_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col && last_row) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + fdmd_pkg::COORD_W'(1);
			end else begin
				col_q <= col_q + fdmd_pkg::COORD_W'(1);
			end
		end
	end

	fdmd_pkg::pixel_pair_t        pix_s1;
	logic [fdmd_pkg::COORD_W-1:0] col_s1;
	logic [fdmd_pkg::COORD_W-1:0] row_s1;
	logic                         first_s1;
	logic                         last_s1;

	// Payload of the input register: capture the request with its position.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pix;
			col_s1   <= col_q;
			row_s1   <= row_q;
			first_s1 <= (col_q == '0) && (row_q == '0);
			last_s1  <= last_col && last_row;
		end
	end

	// ------------------------------------------------------------------
	// Per-pixel work on the input register
	// ------------------------------------------------------------------
	logic [7:0]  diff_b;
	logic [7:0]  diff_g;
	logic [7:0]  diff_r;
	logic [2:0]  flags;
	logic        changed;
	logic [10:0] green_wide;
	logic [7:0]  green_sat;

	assign diff_b = (pix_s1.first_blue > pix_s1.second_blue)
		? pix_s1.first_blue - pix_s1.second_blue : pix_s1.second_blue - pix_s1.first_blue;
	assign diff_g = (pix_s1.first_green > pix_s1.second_green)
		? pix_s1.first_green - pix_s1.second_green : pix_s1.second_green - pix_s1.first_green;
	assign diff_r = (pix_s1.first_red > pix_s1.second_red)
		? pix_s1.first_red - pix_s1.second_red : pix_s1.second_red - pix_s1.first_red;

	assign flags[0] = fdmd_pkg::TOL_W'(diff_b) > tol_q;
	assign flags[1] = fdmd_pkg::TOL_W'(diff_g) > tol_q;
	assign flags[2] = fdmd_pkg::TOL_W'(diff_r) > tol_q;
	assign changed  = |flags;

	// green = min(255, blue * 5 / 2)
	assign green_wide = ({pix_s1.second_blue, 2'b00} + 11'(pix_s1.second_blue)) >> 1;
	assign green_sat  = (green_wide > 11'd255) ? 8'hFF : green_wide[7:0];

	// ------------------------------------------------------------------
	// Frame accumulators: flags, count (plain and times 1000), box
	// ------------------------------------------------------------------
	logic [2:0]                    chan_flags_q;
	logic [fdmd_pkg::COUNT_W-1:0]  count_q;
	logic [fdmd_pkg::SCALED_W-1:0] count_k_q;
	logic [fdmd_pkg::COORD_W-1:0]  min_x_q;
	logic [fdmd_pkg::COORD_W-1:0]  max_x_q;
	logic [fdmd_pkg::COORD_W-1:0]  min_y_q;
	logic [fdmd_pkg::COORD_W-1:0]  max_y_q;
	logic [fdmd_pkg::SCALED_W-1:0] thr_q;

	logic [2:0]                    chan_flags_n;
	logic [fdmd_pkg::COUNT_W-1:0]  count_n;
	logic [fdmd_pkg::SCALED_W-1:0] count_k_n;
	logic [fdmd_pkg::COORD_W-1:0]  min_x_n;
	logic [fdmd_pkg::COORD_W-1:0]  max_x_n;
	logic [fdmd_pkg::COORD_W-1:0]  min_y_n;
	logic [fdmd_pkg::COORD_W-1:0]  max_y_n;
	logic [fdmd_pkg::SCALED_W-1:0] thr_use;
	logic                          high_qty;

	always_comb begin
		chan_flags_n = chan_flags_q | flags;
		count_n      = count_q;
		count_k_n    = count_k_q;
		min_x_n      = min_x_q;
		max_x_n      = max_x_q;
		min_y_n      = min_y_q;
		max_y_n      = max_y_q;
		if (changed) begin
			// saturate the count, and the scaled copy with it
			if (count_q != fdmd_pkg::COUNT_MAX) begin
				count_n   = count_q + fdmd_pkg::COUNT_W'(1);
				count_k_n = count_k_q + fdmd_pkg::PERMILLE_SCALE;
			end
			if (col_s1 < min_x_q) min_x_n = col_s1;
			if (col_s1 > max_x_q) max_x_n = col_s1;
			if (row_s1 < min_y_q) min_y_n = row_s1;
			if (row_s1 > max_y_q) max_y_n = row_s1;
		end
	end

	// The threshold is taken at a frame's first pixel; a one-pixel frame
	// compares against the fresh product directly.
	assign thr_use  = first_s1 ? thr_prod_q : thr_q;
	assign high_qty = count_k_n > thr_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_flags_q <= '0;
			count_q      <= '0;
			count_k_q    <= '0;
			min_x_q      <= fdmd_pkg::COORD_MAX;
			max_x_q      <= '0;
			min_y_q      <= fdmd_pkg::COORD_MAX;
			max_y_q      <= '0;
		end else if (move_s1) begin
			if (last_s1) begin
				// frame reported: start the next one empty
				chan_flags_q <= '0;
				count_q      <= '0;
				count_k_q    <= '0;
				min_x_q      <= fdmd_pkg::COORD_MAX;
				max_x_q      <= '0;
				min_y_q      <= fdmd_pkg::COORD_MAX;
				max_y_q      <= '0;
			end else begin
				chan_flags_q <= chan_flags_n;
				count_q      <= count_n;
				count_k_q    <= count_k_n;
				min_x_q      <= min_x_n;
				max_x_q      <= max_x_n;
				min_y_q      <= min_y_n;
				max_y_q      <= max_y_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && first_s1) begin
			thr_q <= thr_prod_q;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	fdmd_pkg::result_t res_n;
	fdmd_pkg::result_t res_s2;

	always_comb begin
		res_n               = '0;
		res_n.pixel_changed = changed;
		if (changed) begin
			res_n.out_blue  = {1'b0, pix_s1.second_blue[7:1]};
			res_n.out_green = green_sat;
			res_n.out_red   = {1'b0, pix_s1.second_red[7:1]};
		end else begin
			res_n.out_blue  = pix_s1.second_blue;
			res_n.out_green = pix_s1.second_green;
			res_n.out_red   = pix_s1.second_red;
		end
		// summary only on the last pixel; an empty frame reports a zero box
		if (last_s1) begin
			res_n.frame_end     = 1'b1;
			res_n.status_flags  = {high_qty, chan_flags_n};
			res_n.changed_count = count_n;
			if (count_n != '0) begin
				res_n.box_min_x = min_x_n;
				res_n.box_max_x = max_x_n;
				res_n.box_min_y = min_y_n;
				res_n.box_max_y = max_y_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res_n;
		end
	end

	assign res = res_s2;

endmodule
